// ----- hw/rtl/tccg_pkg.sv -----
// ----------------------------------------------------------------------------
// tccg_pkg: shared types and constants of the text console grid writer
// Command and result structs, control character codes, register indexes and
// default grid geometry.
// ----------------------------------------------------------------------------
package tccg_pkg;

	// default grid geometry
	localparam int ROW_MAX_DEF = 32;
	localparam int COL_MAX_DEF = 80;

	// grid cell width
	localparam int CELL_W = 8;

	// field widths of the command and result
	localparam int ROW_FIELD_W = 5;
	localparam int COL_FIELD_W = 7;

	// configuration register widths and reset values
	localparam int NUM_ROWS_W = 6;
	localparam int NUM_COLS_W = 7;
	localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 6'd32;
	localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 7'd80;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

	// command modes
	localparam logic MODE_PUT  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// control characters
	localparam logic [CELL_W-1:0] CH_BS = 8'd8;
	localparam logic [CELL_W-1:0] CH_LF = 8'd10;
	localparam logic [CELL_W-1:0] CH_CR = 8'd13;

	// command transaction
	typedef struct packed {
		logic                   mode;
		logic [CELL_W-1:0]      character;
		logic [ROW_FIELD_W-1:0] read_row;
		logic [COL_FIELD_W-1:0] read_col;
	} cmd_t;

	// result transaction
	typedef struct packed {
		logic [ROW_FIELD_W-1:0] cursor_row;
		logic [COL_FIELD_W-1:0] cursor_col;
		logic                   wrap_pending;
		logic [CELL_W-1:0]      cell_value;
	} result_t;

endpackage

// ----- hw/rtl/tccg_grid_ram.sv -----
// ----------------------------------------------------------------------------
// tccg_grid_ram: character grid storage
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module tccg_grid_ram #(
	parameter int AW = 12,
	parameter int DW = tccg_pkg::CELL_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/text_console_char_grid_writer.sv -----
// A put that starts no new line registers its result and done strobe from idle; a read goes through READ.
// A put that starts a new line also clears the active columns of the new row, one
// cell a cycle through the grid memory write port.
// One put per cycle while no put starts a new line; a read or a line clear holds busy high until done.
// After reset a clearing pass zeroes all 2**(RW+CW) grid cells, one a cycle
// (4096 cells at 32 x 80) with busy high; the receiver cannot stall results.
// ----------------------------------------------------------------------------
// text_console_char_grid_writer: character console grid writer
// Keeps the cursor and wrap flag in registers and the character grid in a
// synchronous memory addressed by {row, column}; sequences puts, raw reads,
// line clears and the reset clearing pass.
// ----------------------------------------------------------------------------
module text_console_char_grid_writer #(
	parameter int ROW_MAX = tccg_pkg::ROW_MAX_DEF,
	parameter int COL_MAX = tccg_pkg::COL_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  tccg_pkg::cmd_t                  cmd,
	output logic                            done,
	output tccg_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tccg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tccg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int RW  = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
	localparam int CW  = (COL_MAX > 1) ? $clog2(COL_MAX) : 1;
	localparam int AW  = RW + CW;
	localparam int RAW = $clog2(ROW_MAX + 1);
	localparam int CAW = $clog2(COL_MAX + 1);

	typedef enum logic [3:0] {
		ST_INIT  = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

	state_t                              state_q;
	logic [AW-1:0]                       init_addr_q;
	logic [CW-1:0]                       clr_col_q;
	logic [RW-1:0]                       row_q;
	logic [CW-1:0]                       col_q;
	logic                                pw_q;
	logic [tccg_pkg::NUM_ROWS_W-1:0]     num_rows_q;
	logic [tccg_pkg::NUM_COLS_W-1:0]     num_cols_q;
	logic                                rd_ok_q;
	logic                                done_q;
	tccg_pkg::result_t                   result_q;

	logic [RAW-1:0]                      rows_act;
	logic [CAW-1:0]                      cols_act;
	logic [RAW-1:0]                      rows_new;
	logic [CAW-1:0]                      cols_new;
	logic                                accept;
	logic                                accept_put;
	logic                                accept_read;
	logic                                cfg_fire;
	logic                                clear_last;
	logic                                init_last;

	logic [RW-1:0]                       row_nxt;
	logic [CW-1:0]                       col_nxt;
	logic                                pw_nxt;
	logic                                put_we;
	logic                                new_line;

	logic                                ram_we;
	logic [AW-1:0]                       ram_waddr;
	logic [tccg_pkg::CELL_W-1:0]         ram_wdata;
	logic                                ram_re;
	logic [AW-1:0]                       ram_raddr;
	logic [tccg_pkg::CELL_W-1:0]         ram_rdata;

	// active row count from a register value: zero counts as one, clipped at the grid
	function automatic logic [RAW-1:0] act_rows(input logic [tccg_pkg::NUM_ROWS_W-1:0] n);
		logic [RAW-1:0] r;
		if (n == '0) begin
			r = RAW'(1);
		end else if (32'(n) > 32'(ROW_MAX)) begin
			r = RAW'(ROW_MAX);
		end else begin
			r = RAW'(32'(n));
		end
		return r;
	endfunction

	// active column count from a register value
	function automatic logic [CAW-1:0] act_cols(input logic [tccg_pkg::NUM_COLS_W-1:0] n);
		logic [CAW-1:0] c;
		if (n == '0) begin
			c = CAW'(1);
		end else if (32'(n) > 32'(COL_MAX)) begin
			c = CAW'(COL_MAX);
		end else begin
			c = CAW'(32'(n));
		end
		return c;
	endfunction

	// handshakes; register writes only while idle with no command offered
	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign accept_put  = accept && (cmd.mode == tccg_pkg::MODE_PUT);
	assign accept_read = accept && (cmd.mode == tccg_pkg::MODE_READ);
	assign cfg_ready   = !busy && !start;
	assign cfg_fire    = cfg_valid && cfg_ready;

	// active area, current and after a register write
	assign rows_act = act_rows(num_rows_q);
	assign cols_act = act_cols(num_cols_q);
	assign rows_new = (cfg_index == tccg_pkg::CFG_NUM_ROWS) ?
		act_rows(cfg_data[tccg_pkg::NUM_ROWS_W-1:0]) : rows_act;
	assign cols_new = (cfg_index == tccg_pkg::CFG_NUM_COLS) ?
		act_cols(cfg_data[tccg_pkg::NUM_COLS_W-1:0]) : cols_act;

	// sweep end conditions
	assign clear_last = (state_q == ST_CLEAR) && (32'(clr_col_q) + 32'd1 >= 32'(cols_act));
	assign init_last  = (init_addr_q == '1);

	// cursor update of a put
	always_comb begin
		row_nxt  = row_q;
		col_nxt  = col_q;
		pw_nxt   = pw_q;
		put_we   = 1'b0;
		new_line = 1'b0;
		case (cmd.character)
			tccg_pkg::CH_LF: begin
				new_line = !pw_q;
				pw_nxt   = 1'b0;
			end
			tccg_pkg::CH_BS: begin
				if (col_q == '0) begin
					col_nxt = CW'(cols_act - CAW'(1));
					if (row_q == '0) begin
						row_nxt = RW'(rows_act - RAW'(1));
						pw_nxt  = 1'b0;
					end else begin
						row_nxt = row_q - RW'(1);
					end
				end else begin
					col_nxt = col_q - CW'(1);
				end
			end
			tccg_pkg::CH_CR: begin
				col_nxt = '0;
			end
			default: begin
				put_we = 1'b1;
				pw_nxt = 1'b0;
				if (32'(col_q) + 32'd1 >= 32'(cols_act)) begin
					new_line = 1'b1;
					pw_nxt   = 1'b1;
				end else begin
					col_nxt = col_q + CW'(1);
				end
			end
		endcase
		// new line: advance the row circularly
		if (new_line) begin
			col_nxt = '0;
			row_nxt = (32'(row_q) + 32'd1 >= 32'(rows_act)) ? '0 : row_q + RW'(1);
		end
	end

	// grid write port select
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {row_q, col_q};
		ram_wdata = '0;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_addr_q;
			end
			ST_IDLE: begin
				ram_we    = accept_put && put_we;
				ram_wdata = cmd.character;
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = {row_q, clr_col_q};
			end
			ST_READ: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// grid read port: reads are only issued from idle, after earlier writes landed
	assign ram_re    = accept_read;
	assign ram_raddr = {RW'(32'(cmd.read_row)), CW'(32'(cmd.read_col))};

	tccg_grid_ram #(
		.AW (AW),
		.DW (tccg_pkg::CELL_W)
	) u_grid_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, cursor and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_addr_q <= '0;
			clr_col_q   <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pw_q        <= 1'b0;
			num_rows_q  <= tccg_pkg::NUM_ROWS_RST;
			num_cols_q  <= tccg_pkg::NUM_COLS_RST;
			rd_ok_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					init_addr_q <= init_addr_q + AW'(1);
					if (init_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept_read) begin
						rd_ok_q <= (32'(cmd.read_row) < 32'(ROW_MAX)) &&
							(32'(cmd.read_col) < 32'(COL_MAX));
						state_q <= ST_READ;
					end else if (accept_put) begin
						row_q <= row_nxt;
						col_q <= col_nxt;
						pw_q  <= pw_nxt;
						if (new_line) begin
							clr_col_q <= '0;
							state_q   <= ST_CLEAR;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					clr_col_q <= clr_col_q + CW'(1);
					if (clear_last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// register write, cursor pulled back inside a smaller area
			if (cfg_fire) begin
				case (cfg_index)
					tccg_pkg::CFG_NUM_ROWS: begin
						num_rows_q <= cfg_data[tccg_pkg::NUM_ROWS_W-1:0];
					end
					tccg_pkg::CFG_NUM_COLS: begin
						num_cols_q <= cfg_data[tccg_pkg::NUM_COLS_W-1:0];
					end
					default: begin
					end
				endcase
				if ((cfg_index == tccg_pkg::CFG_NUM_ROWS) ||
					(cfg_index == tccg_pkg::CFG_NUM_COLS)) begin
					if (32'(row_q) >= 32'(rows_new)) begin
						row_q <= '0;
					end
					if (32'(col_q) >= 32'(cols_new)) begin
						col_q <= '0;
					end
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept_put && !new_line) begin
			result_q.cursor_row   <= tccg_pkg::ROW_FIELD_W'(32'(row_nxt));
			result_q.cursor_col   <= tccg_pkg::COL_FIELD_W'(32'(col_nxt));
			result_q.wrap_pending <= pw_nxt;
			result_q.cell_value   <= '0;
		end else if (state_q == ST_READ) begin
			result_q.cursor_row   <= tccg_pkg::ROW_FIELD_W'(32'(row_q));
			result_q.cursor_col   <= tccg_pkg::COL_FIELD_W'(32'(col_q));
			result_q.wrap_pending <= pw_q;
			result_q.cell_value   <= rd_ok_q ? ram_rdata : '0;
		end else if (clear_last) begin
			result_q.cursor_row   <= tccg_pkg::ROW_FIELD_W'(32'(row_q));
			result_q.cursor_col   <= tccg_pkg::COL_FIELD_W'(32'(col_q));
			result_q.wrap_pending <= pw_q;
			result_q.cell_value   <= '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a read always answers in the next cycle
	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> done)
		else $error("read did not produce a result");

	// every strobe comes from a plain put, a read or the end of a line clear
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past((accept_put && !new_line) || (state_q == ST_READ) || clear_last))
		else $error("result strobe without a finished transaction");

	// the cursor stays inside the active area whenever commands are taken
	a_cursor_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (32'(row_q) < 32'(rows_act)) && (32'(col_q) < 32'(cols_act)))
		else $error("cursor outside the active area");

	// the line clear never runs past the last active column
	a_clear_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> 32'(clr_col_q) < 32'(cols_act))
		else $error("line clear past the active columns");

endmodule
